[hdl/frwt_pkg.sv]
`default_nettype none

package frwt_pkg;

  // fixed field widths
  localparam int SEQ_W    = 31;
  localparam int PART_W   = 16;
  localparam int IDENT_W  = 8;
  localparam int STATUS_W = 3;
  localparam int READY_W  = 5;

  typedef logic [STATUS_W-1:0] status_t;

  // only accepted format byte ('x')
  localparam logic [IDENT_W-1:0] VALID_IDENT = 8'd120;

  // command codes
  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_CONSUME = 1'b1;

  // result status codes
  localparam status_t ST_ACCEPTED   = 3'd0;
  localparam status_t ST_BAD_IDENT  = 3'd1;
  localparam status_t ST_TOO_FAR    = 3'd2;
  localparam status_t ST_TOO_LATE   = 3'd3;
  localparam status_t ST_PART_RANGE = 3'd4;
  localparam status_t ST_DUPLICATE  = 3'd5;
  localparam status_t ST_READY      = 3'd6;
  localparam status_t ST_NOT_READY  = 3'd7;

endpackage

`default_nettype wire

[hdl/frwt_ram.sv]
`default_nettype none

module frwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/fragment_receive_window_tracker_unit.sv]
`default_nettype none

// channel   | dir | handshake           | payload
// ----------+-----+---------------------+--------------------------------------------
// input     | in  | in_valid / in_stall | command ident msg_seq part_count part_index
//           |     |                     | ack_seq ack_part
// result    | out | out_valid/out_stall | status need_seq_out need_part_out
//           |     |                     | peer_seq_out peer_part_out ready_parts
//
// one item in flight; in_stall is high from acceptance until its result is handed to
// the output register, which then waits for the receiver on its own
// consume item: slot read, completeness check, then the result; rejected header: format
// and window check and, inside the window, the entry check; accepted header: entry written,
// then the need walk, which reads each visited slot from the single-port slot table in turn
// reset (rst, synchronous) empties every slot through per-slot valid flops at once
// a stalled result holds in the output register while the next item is already worked on

module fragment_receive_window_tracker_unit #(
  parameter int RING_SLOTS = 8,
  parameter int MAX_PARTS  = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           command,
  input  wire logic [frwt_pkg::IDENT_W-1:0]   ident,
  input  wire logic [frwt_pkg::SEQ_W-1:0]     msg_seq,
  input  wire logic [frwt_pkg::PART_W-1:0]    part_count,
  input  wire logic [frwt_pkg::PART_W-1:0]    part_index,
  input  wire logic [frwt_pkg::SEQ_W-1:0]     ack_seq,
  input  wire logic [frwt_pkg::PART_W-1:0]    ack_part,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output frwt_pkg::status_t                   status,
  output logic      [frwt_pkg::SEQ_W-1:0]     need_seq_out,
  output logic      [frwt_pkg::PART_W-1:0]    need_part_out,
  output logic      [frwt_pkg::SEQ_W-1:0]     peer_seq_out,
  output logic      [frwt_pkg::PART_W-1:0]    peer_part_out,
  output logic      [frwt_pkg::READY_W-1:0]   ready_parts
);

  localparam int SEQ_W  = frwt_pkg::SEQ_W;
  localparam int PART_W = frwt_pkg::PART_W;
  localparam int SW     = $clog2(RING_SLOTS);
  localparam int CW     = $clog2(MAX_PARTS + 1);
  localparam int PIW    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int AW     = $clog2(RING_SLOTS + 2);
  localparam int EW     = CW + MAX_PARTS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_HDR   = 3'd2;
  localparam logic [2:0] S_CONS  = 3'd3;
  localparam logic [2:0] S_WREQ  = 3'd4;
  localparam logic [2:0] S_WCHK  = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;

  logic [2:0] state;

  // captured item
  logic                            cmd_r;
  logic [frwt_pkg::IDENT_W-1:0]    ident_r;
  logic [SEQ_W-1:0]                msg_r;
  logic [PART_W-1:0]               cnt_in_r;
  logic [PART_W-1:0]               part_r;
  logic [SEQ_W-1:0]                aseq_r;
  logic [PART_W-1:0]               apart_r;

  // tracker state
  logic [SEQ_W-1:0]      read_seq;
  logic [SW-1:0]         read_slot;     // read_seq mod ring
  logic [SEQ_W-1:0]      need_seq;
  logic [SW-1:0]         need_slot;     // need_seq mod ring
  logic [PART_W-1:0]     need_part;
  logic [SEQ_W-1:0]      peer_seq;
  logic [PART_W-1:0]     peer_part;
  logic [RING_SLOTS-1:0] vld;           // slot holds a message
  logic                  vld_q;         // valid bit of the slot just read
  logic [SW-1:0]         hslot;         // slot of the header's message
  logic [AW-1:0]         adv;           // messages passed in this walk
  frwt_pkg::status_t     st_r;
  logic [frwt_pkg::READY_W-1:0] rdy_r;

  // slot table port
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [SW-1:0] ram_raddr;
  logic [EW-1:0] ram_q;

  frwt_ram #(
    .WIDTH (EW),
    .DEPTH (RING_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // entry as read, empty slot reads as zero
  logic [CW-1:0]        e_cnt;
  logic [MAX_PARTS-1:0] e_rec;

  assign e_cnt = vld_q ? ram_q[EW-1:MAX_PARTS] : '0;
  assign e_rec = vld_q ? ram_q[MAX_PARTS-1:0] : '0;

  // slot of message read_seq+1
  logic [SW-1:0] cons_slot;
  assign cons_slot = (read_slot == SW'(RING_SLOTS - 1)) ? '0 : read_slot + SW'(1);

  // header window checks and slot of msg_seq
  logic          peer_gt;
  logic [SEQ_W:0] win_hi;
  logic          too_far;
  logic          too_late;
  logic [SW-1:0] diff;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] msg_slot;

  always_comb begin
    peer_gt  = {aseq_r, apart_r} > {peer_seq, peer_part};
    win_hi   = {1'b0, read_seq} + (SEQ_W+1)'(RING_SLOTS - 1);
    too_far  = {1'b0, msg_r} > win_hi;
    too_late = msg_r <= read_seq;
    // message lies within ring slots ahead of read, low bits of the distance suffice
    diff     = msg_r[SW-1:0] - read_seq[SW-1:0];
    slot_sum = {1'b0, read_slot} + {1'b0, diff};
    if (slot_sum >= (SW+1)'(RING_SLOTS)) begin
      msg_slot = SW'(slot_sum - (SW+1)'(RING_SLOTS));
    end else begin
      msg_slot = SW'(slot_sum);
    end
  end

  // header against the stored entry
  logic                 fresh;
  logic [CW-1:0]        cnt_eff;
  logic [MAX_PARTS-1:0] bit_sel;
  logic                 part_bad;
  logic                 dup;
  logic                 hdr_acc;
  logic                 hdr_wr;

  always_comb begin
    fresh = !vld_q;
    if (!fresh) begin
      cnt_eff = e_cnt;
    end else if (cnt_in_r > PART_W'(MAX_PARTS)) begin
      cnt_eff = '0;
    end else begin
      cnt_eff = CW'(cnt_in_r);
    end
    bit_sel  = MAX_PARTS'(1) << part_r[PIW-1:0];
    part_bad = part_r >= PART_W'(cnt_eff);
    dup      = |(e_rec & bit_sel);
    hdr_acc  = !part_bad && !dup;
    // a fresh slot keeps its count even when the fragment itself is refused
    hdr_wr   = (fresh && (cnt_eff != '0)) || hdr_acc;
  end

  // consume completeness
  logic [MAX_PARTS-1:0] cmask;
  logic                 cons_ok;

  always_comb begin
    for (int i = 0; i < MAX_PARTS; i++) begin
      cmask[i] = 32'(i) < 32'(e_cnt);
    end
    cons_ok = (e_cnt != '0) && ((e_rec & cmask) == cmask);
  end

  // need walk step
  logic              seq_ahead;
  logic              np_ge;
  logic              cur_bit;
  logic [SEQ_W-1:0]  need_seq_inc;
  logic [SW-1:0]     need_slot_inc;
  logic [SEQ_W-1:0]  read_seq_inc;

  always_comb begin
    seq_ahead     = need_seq > read_seq;
    np_ge         = need_part >= PART_W'(e_cnt);
    cur_bit       = e_rec[need_part[PIW-1:0]];
    need_seq_inc  = need_seq + SEQ_W'(1);
    if (need_seq_inc == '0) begin
      need_slot_inc = '0;
    end else if (need_slot == SW'(RING_SLOTS - 1)) begin
      need_slot_inc = '0;
    end else begin
      need_slot_inc = need_slot + SW'(1);
    end
    read_seq_inc  = read_seq + SEQ_W'(1);
  end

  // slot table access: reads in check and walk-request states, write in header state
  always_comb begin
    ram_re    = state inside {S_CHECK, S_WREQ};
    ram_raddr = need_slot;
    if (state == S_CHECK) begin
      ram_raddr = (cmd_r == frwt_pkg::CMD_CONSUME) ? cons_slot : msg_slot;
    end
    ram_we    = (state == S_HDR) && hdr_wr;
    ram_waddr = hslot;
    ram_wdata = {cnt_eff, e_rec | (hdr_acc ? bit_sel : '0)};
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      read_seq  <= '0;
      read_slot <= '0;
      need_seq  <= SEQ_W'(1);
      need_slot <= SW'(1);
      need_part <= '0;
      peer_seq  <= '0;
      peer_part <= '0;
      vld       <= '0;
      vld_q     <= 1'b0;
      adv       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ram_re) begin
        vld_q <= vld[ram_raddr];
      end
      // the put state loads the output register itself
      if (out_valid && !out_stall && (state != S_PUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= command;
            ident_r  <= ident;
            msg_r    <= msg_seq;
            cnt_in_r <= part_count;
            part_r   <= part_index;
            aseq_r   <= ack_seq;
            apart_r  <= ack_part;
            state    <= S_CHECK;
          end
        end

        S_CHECK: begin
          rdy_r <= '0;
          hslot <= msg_slot;
          if (cmd_r == frwt_pkg::CMD_CONSUME) begin
            state <= S_CONS;
          end else if (ident_r != frwt_pkg::VALID_IDENT) begin
            // bad format byte leaves even the peer position alone
            st_r  <= frwt_pkg::ST_BAD_IDENT;
            state <= S_PUT;
          end else begin
            if (peer_gt) begin
              peer_seq  <= aseq_r;
              peer_part <= apart_r;
            end
            if (too_far) begin
              st_r  <= frwt_pkg::ST_TOO_FAR;
              state <= S_PUT;
            end else if (too_late) begin
              st_r  <= frwt_pkg::ST_TOO_LATE;
              state <= S_PUT;
            end else begin
              state <= S_HDR;
            end
          end
        end

        S_HDR: begin
          adv <= '0;
          if (hdr_wr) begin
            vld[hslot] <= 1'b1;
          end
          if (part_bad) begin
            st_r  <= frwt_pkg::ST_PART_RANGE;
            state <= S_PUT;
          end else if (dup) begin
            st_r  <= frwt_pkg::ST_DUPLICATE;
            state <= S_PUT;
          end else begin
            st_r  <= frwt_pkg::ST_ACCEPTED;
            state <= S_WREQ;
          end
        end

        S_CONS: begin
          if (cons_ok) begin
            st_r           <= frwt_pkg::ST_READY;
            rdy_r          <= frwt_pkg::READY_W'(e_cnt);
            vld[cons_slot] <= 1'b0;
            read_seq       <= read_seq_inc;
            // slot follows the masked sequence back to zero on wrap
            read_slot      <= (read_seq_inc == '0) ? '0 : cons_slot;
          end else begin
            st_r <= frwt_pkg::ST_NOT_READY;
          end
          state <= S_PUT;
        end

        S_WREQ: begin
          state <= S_WCHK;
        end

        S_WCHK: begin
          if (seq_ahead && (e_cnt == '0)) begin
            state <= S_PUT;
          end else if (np_ge) begin
            if (adv == AW'(RING_SLOTS + 1)) begin
              state <= S_PUT;
            end else begin
              adv       <= adv + AW'(1);
              need_seq  <= need_seq_inc;
              need_slot <= need_slot_inc;
              need_part <= '0;
              state     <= S_WREQ;
            end
          end else if (!cur_bit) begin
            state <= S_PUT;
          end else begin
            need_part <= need_part + PART_W'(1);
          end
        end

        S_PUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= st_r;
            need_seq_out  <= need_seq;
            need_part_out <= need_part;
            peer_seq_out  <= peer_seq;
            peer_part_out <= peer_part;
            ready_parts   <= rdy_r;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // only a ready message carries a fragment count
  a_ready_parts_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != frwt_pkg::ST_READY)) |-> (ready_parts == '0))
    else $error("ready_parts set on a result that is not message ready");

  // the walk never passes more than ring+1 messages
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    adv <= AW'(RING_SLOTS + 1))
    else $error("need walk ran past its bound");

  // a ready consume moves read forward by exactly one
  a_read_advance: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CONS) && cons_ok) |=> (read_seq == $past(read_seq_inc)))
    else $error("read sequence did not advance on a ready consume");

  // a slot written by a header is marked as holding a message
  a_slot_marked: assert property (@(posedge clk) disable iff (rst)
    ((state == S_HDR) && hdr_wr) |=> vld[$past(hslot)])
    else $error("written slot not marked valid");

  // slot table never read and written in the same cycle
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("slot table read and write collide");

endmodule

`default_nettype wire

[tb/frwt_checker.sv]
`default_nettype none

module frwt_checker #(
  parameter int RING_SLOTS = 8,
  parameter int MAX_PARTS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic                         command,
  input  wire logic [frwt_pkg::IDENT_W-1:0] ident,
  input  wire logic [frwt_pkg::SEQ_W-1:0]   msg_seq,
  input  wire logic [frwt_pkg::PART_W-1:0]  part_count,
  input  wire logic [frwt_pkg::PART_W-1:0]  part_index,
  input  wire logic [frwt_pkg::SEQ_W-1:0]   ack_seq,
  input  wire logic [frwt_pkg::PART_W-1:0]  ack_part,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire frwt_pkg::status_t            status,
  input  wire logic [frwt_pkg::SEQ_W-1:0]   need_seq_out,
  input  wire logic [frwt_pkg::PART_W-1:0]  need_part_out,
  input  wire logic [frwt_pkg::SEQ_W-1:0]   peer_seq_out,
  input  wire logic [frwt_pkg::PART_W-1:0]  peer_part_out,
  input  wire logic [frwt_pkg::READY_W-1:0] ready_parts,
  output int                                fail_count,
  output int                                pending,
  output int                                report_count,
  output logic [7:0]                        status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import frwt_pkg::*;

  typedef struct packed {
    logic               command;
    logic [IDENT_W-1:0] ident;
    logic [SEQ_W-1:0]   msg_seq;
    logic [PART_W-1:0]  part_count;
    logic [PART_W-1:0]  part_index;
    logic [SEQ_W-1:0]   ack_seq;
    logic [PART_W-1:0]  ack_part;
  } frag_item_t;

  typedef struct packed {
    status_t            status;
    logic [SEQ_W-1:0]   need_seq;
    logic [PART_W-1:0]  need_part;
    logic [SEQ_W-1:0]   peer_seq;
    logic [PART_W-1:0]  peer_part;
    logic [READY_W-1:0] ready_parts;
  } window_report_t;

  // tracker state as the block should hold it
  logic [SEQ_W-1:0]     read_pos;
  logic [SEQ_W-1:0]     need_pos;
  logic [PART_W-1:0]    need_frag;
  logic [SEQ_W-1:0]     peer_pos;
  logic [PART_W-1:0]    peer_frag;
  logic [READY_W-1:0]   slot_parts [RING_SLOTS];
  logic [MAX_PARTS-1:0] slot_got   [RING_SLOTS];

  window_report_t expected_reports [$];

  function automatic void clear_window();
    read_pos  = '0;
    need_pos  = SEQ_W'(1);
    need_frag = '0;
    peer_pos  = '0;
    peer_frag = '0;
    for (int i = 0; i < RING_SLOTS; i++) begin
      slot_parts[i] = '0;
      slot_got[i]   = '0;
    end
  endfunction

  // step the need pointer over received fragments and finished messages
  function automatic void walk_need_pointer();
    int hops;
    int s;
    bit busy;
    hops = 0;
    busy = 1'b1;
    while (busy) begin
      s = int'(need_pos % RING_SLOTS);
      if (need_pos > read_pos && slot_parts[s] == 0) begin
        busy = 1'b0;
      end else if (need_frag >= slot_parts[s]) begin
        if (hops >= RING_SLOTS + 1) begin
          busy = 1'b0;
        end else begin
          hops++;
          need_pos  = need_pos + 1'b1;
          need_frag = '0;
        end
      end else if (!slot_got[s][need_frag]) begin
        busy = 1'b0;
      end else begin
        need_frag = need_frag + 1'b1;
      end
    end
  endfunction

  function automatic status_t admit_fragment(frag_item_t it);
    longint unsigned seq;
    longint unsigned base;
    int s;
    if (it.ident != VALID_IDENT) return ST_BAD_IDENT;
    if (peer_pos < it.ack_seq || (peer_pos == it.ack_seq && peer_frag < it.ack_part)) begin
      peer_pos  = it.ack_seq;
      peer_frag = it.ack_part;
    end
    seq  = 64'(it.msg_seq);
    base = 64'(read_pos);
    if (seq > base + RING_SLOTS - 1) return ST_TOO_FAR;
    if (seq <= base) return ST_TOO_LATE;
    s = int'(seq % RING_SLOTS);
    if (slot_parts[s] == 0) begin
      if (it.part_count > MAX_PARTS) return ST_PART_RANGE;
      slot_parts[s] = it.part_count[READY_W-1:0];
      slot_got[s]   = '0;
    end
    if (it.part_index >= slot_parts[s]) return ST_PART_RANGE;
    if (slot_got[s][it.part_index]) return ST_DUPLICATE;
    slot_got[s][it.part_index] = 1'b1;
    walk_need_pointer();
    return ST_ACCEPTED;
  endfunction

  function automatic window_report_t track_item(frag_item_t it);
    window_report_t rep;
    int s;
    logic [MAX_PARTS:0] full;
    rep.ready_parts = '0;
    if (it.command == CMD_HEADER) begin
      rep.status = admit_fragment(it);
    end else begin
      s    = int'((longint'(read_pos) + 1) % RING_SLOTS);
      full = ({{MAX_PARTS{1'b0}}, 1'b1} << slot_parts[s]) - 1'b1;
      if (slot_parts[s] != 0 && ({1'b0, slot_got[s]} & full) == full) begin
        rep.status      = ST_READY;
        rep.ready_parts = slot_parts[s];
        slot_parts[s]   = '0;
        slot_got[s]     = '0;
        read_pos        = read_pos + 1'b1;
      end else begin
        rep.status = ST_NOT_READY;
      end
    end
    rep.need_seq  = need_pos;
    rep.need_part = need_frag;
    rep.peer_seq  = peer_pos;
    rep.peer_part = peer_frag;
    return rep;
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    window_report_t want;
    if (rst) begin
      clear_window();
      expected_reports.delete();
      fail_count   = 0;
      report_count = 0;
      status_seen  = '0;
    end else begin
      if (out_valid && !out_stall) begin
        report_count++;
        status_seen[status] = 1'b1;
        if (expected_reports.size() == 0) begin
          $display("%0t ns: result with no item outstanding, status %0d", $time, status);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("status", want.status, status);
          compare_field("need_seq_out", want.need_seq, need_seq_out);
          compare_field("need_part_out", want.need_part, need_part_out);
          compare_field("peer_seq_out", want.peer_seq, peer_seq_out);
          compare_field("peer_part_out", want.peer_part, peer_part_out);
          compare_field("ready_parts", want.ready_parts, ready_parts);
        end
      end
      if (in_valid && !in_stall) begin
        expected_reports.push_back(track_item({command, ident, msg_seq, part_count,
                                                part_index, ack_seq, ack_part}));
      end
    end
    pending = expected_reports.size();
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import frwt_pkg::*;

  localparam int RING  = 8;
  localparam int PARTS = 16;
  // item budget and run bounds
  localparam int ITEMS = 1050;
  localparam int DRAIN = 64;
  localparam int LIMIT = 1_000_000;

  // kinds of malformed or off-window traffic mixed into the random part
  typedef enum int {
    NZ_IDENT,
    NZ_FAR,
    NZ_LATE,
    NZ_RANGE,
    NZ_REPEAT,
    NZ_CONSUME,
    NZ_EMPTY_COUNT
  } noise_kind_t;

  logic clk = 1'b0;
  logic rst;

  logic                in_valid;
  logic                in_stall;
  logic                command;
  logic [IDENT_W-1:0]  ident;
  logic [SEQ_W-1:0]    msg_seq;
  logic [PART_W-1:0]   part_count;
  logic [PART_W-1:0]   part_index;
  logic [SEQ_W-1:0]    ack_seq;
  logic [PART_W-1:0]   ack_part;
  logic                out_valid;
  logic                out_stall;
  status_t             status;
  logic [SEQ_W-1:0]    need_seq_out;
  logic [PART_W-1:0]   need_part_out;
  logic [SEQ_W-1:0]    peer_seq_out;
  logic [PART_W-1:0]   peer_part_out;
  logic [READY_W-1:0]  ready_parts;

  int         fail_count;
  int         checker_pending;
  int         report_count;
  logic [7:0] status_seen;

  // pacing of both sides, changed by phase as items go out
  int send_idle_pct  = 17;
  int recv_stall_pct = 63;
  int items_sent     = 0;
  int header_items   = 0;
  int consume_items  = 0;
  int cycle_count    = 0;

  // light mirror of the window, only used to shape well-formed traffic
  logic [SEQ_W-1:0]  gen_read;
  int                gen_cnt  [RING];
  logic [PART_W-1:0] gen_sent [RING];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fragment_receive_window_tracker_unit #(
    .RING_SLOTS(RING),
    .MAX_PARTS (PARTS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .ident        (ident),
    .msg_seq      (msg_seq),
    .part_count   (part_count),
    .part_index   (part_index),
    .ack_seq      (ack_seq),
    .ack_part     (ack_part),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .need_seq_out (need_seq_out),
    .need_part_out(need_part_out),
    .peer_seq_out (peer_seq_out),
    .peer_part_out(peer_part_out),
    .ready_parts  (ready_parts)
  );

  frwt_checker #(
    .RING_SLOTS(RING),
    .MAX_PARTS (PARTS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .ident        (ident),
    .msg_seq      (msg_seq),
    .part_count   (part_count),
    .part_index   (part_index),
    .ack_seq      (ack_seq),
    .ack_part     (ack_part),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .need_seq_out (need_seq_out),
    .need_part_out(need_part_out),
    .peer_seq_out (peer_seq_out),
    .peer_part_out(peer_part_out),
    .ready_parts  (ready_parts),
    .fail_count   (fail_count),
    .pending      (checker_pending),
    .report_count (report_count),
    .status_seen  (status_seen)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding", LIMIT,
               checker_pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int slot_of(logic [SEQ_W-1:0] seq);
    return int'(seq % RING);
  endfunction

  // all fragments of the message in slot s have gone out
  function automatic bit gen_complete(int s);
    return gen_cnt[s] != 0 && gen_sent[s] == PART_W'((32'd1 << gen_cnt[s]) - 1);
  endfunction

  // one item over the input channel; called at a falling edge, returns at one
  task automatic drive_item(input logic cmd, input logic [IDENT_W-1:0] id,
                            input logic [SEQ_W-1:0] seq, input logic [PART_W-1:0] cnt,
                            input logic [PART_W-1:0] part, input logic [SEQ_W-1:0] aseq,
                            input logic [PART_W-1:0] apart);
    int gap;
    // phases: slow receiver, then slow sender, then full speed on both sides
    if (items_sent < ITEMS / 3) begin
      send_idle_pct  = 17;
      recv_stall_pct = 63;
    end else if (items_sent < 2 * ITEMS / 3) begin
      send_idle_pct  = 63;
      recv_stall_pct = 17;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    ident      <= id;
    msg_seq    <= seq;
    part_count <= cnt;
    part_index <= part;
    ack_seq    <= aseq;
    ack_part   <= apart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic put_header(input logic [IDENT_W-1:0] id, input logic [SEQ_W-1:0] seq,
                            input logic [PART_W-1:0] cnt, input logic [PART_W-1:0] part,
                            input logic [SEQ_W-1:0] aseq, input logic [PART_W-1:0] apart);
    longint unsigned pos;
    longint unsigned base;
    int s;
    drive_item(CMD_HEADER, id, seq, cnt, part, aseq, apart);
    header_items++;
    pos  = 64'(seq);
    base = 64'(gen_read);
    // keep the mirror in step for fragments that land inside the window
    if (id == VALID_IDENT && pos > base && pos <= base + RING - 1) begin
      s = slot_of(seq);
      if (gen_cnt[s] == 0 && cnt <= PARTS) begin
        gen_cnt[s]  = int'(cnt);
        gen_sent[s] = '0;
      end
      if (part < gen_cnt[s]) gen_sent[s][part] = 1'b1;
    end
  endtask

  // consume request; the header fields ride along as junk
  task automatic put_consume();
    int s;
    drive_item(CMD_CONSUME, IDENT_W'($urandom), SEQ_W'($urandom), PART_W'($urandom),
               PART_W'($urandom), SEQ_W'($urandom), PART_W'($urandom));
    consume_items++;
    s = slot_of(gen_read + 1'b1);
    if (gen_complete(s)) begin
      gen_cnt[s]  = 0;
      gen_sent[s] = '0;
      gen_read    = gen_read + 1'b1;
    end
  endtask

  // peer position close to the read point; fully random near the end of the run
  task automatic pick_ack(output logic [SEQ_W-1:0] aseq, output logic [PART_W-1:0] apart);
    if (items_sent >= ITEMS - 60) begin
      aseq  = SEQ_W'($urandom);
      apart = PART_W'($urandom);
    end else begin
      aseq  = gen_read + SEQ_W'($urandom_range(0, 2));
      apart = PART_W'($urandom_range(0, 20));
    end
  endtask

  // a fresh fragment of a message inside the window, lower sequences favored; if whole, a consume or a repeat
  task automatic send_fragment();
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  aseq;
    logic [PART_W-1:0] apart;
    int s;
    int cnt;
    int start;
    int p;
    seq = gen_read + SEQ_W'($urandom_range(1, $urandom_range(1, RING - 1)));
    s   = slot_of(seq);
    if (gen_cnt[s] == 0) cnt = ($urandom_range(0, 9) == 0) ? PARTS : $urandom_range(1, 4);
    else cnt = gen_cnt[s];
    start = $urandom_range(0, cnt - 1);
    p     = -1;
    for (int k = 0; k < cnt; k++) begin
      if (p < 0 && !gen_sent[s][(start + k) % cnt]) p = (start + k) % cnt;
    end
    if (p < 0) begin
      // message already whole: drain the head, or else repeat a fragment
      if (gen_complete(slot_of(gen_read + 1'b1))) put_consume();
      else p = start;
    end
    if (p >= 0) begin
      pick_ack(aseq, apart);
      put_header(VALID_IDENT, seq, PART_W'(cnt), PART_W'(p), aseq, apart);
    end
  endtask

  task automatic send_noise();
    noise_kind_t       kind;
    logic [IDENT_W-1:0] id;
    logic [SEQ_W-1:0]  seq;
    logic [PART_W-1:0] cnt;
    logic [PART_W-1:0] part;
    logic [SEQ_W-1:0]  aseq;
    logic [PART_W-1:0] apart;
    int s;
    kind = noise_kind_t'($urandom_range(0, 6));
    id   = VALID_IDENT;
    seq  = gen_read + SEQ_W'($urandom_range(1, RING - 1));
    cnt  = PART_W'($urandom_range(1, 4));
    part = '0;
    pick_ack(aseq, apart);
    if (kind == NZ_CONSUME) begin
      put_consume();
    end else begin
      case (kind)
        NZ_IDENT: begin
          id = IDENT_W'($urandom);
          if (id == VALID_IDENT) id = ~id;
          seq   = SEQ_W'($urandom);
          cnt   = PART_W'($urandom);
          part  = PART_W'($urandom);
          aseq  = SEQ_W'($urandom);
          apart = PART_W'($urandom);
        end
        NZ_FAR: begin
          if ($urandom_range(0, 1) == 0) seq = SEQ_W'($urandom);
          else seq = gen_read + SEQ_W'(RING + $urandom_range(0, 3));
        end
        NZ_LATE: begin
          seq = gen_read - SEQ_W'($urandom_range(0, 3));
        end
        NZ_RANGE: begin
          cnt  = PART_W'($urandom);
          part = PART_W'($urandom);
        end
        NZ_REPEAT: begin
          s    = slot_of(seq);
          cnt  = PART_W'(gen_cnt[s]);
          part = PART_W'($urandom_range(0, (gen_cnt[s] > 0) ? gen_cnt[s] - 1 : 0));
        end
        default: begin
          // zero or oversized count on a message that may not be open yet
          if ($urandom_range(0, 1) == 0) cnt = '0;
          else cnt = PART_W'($urandom_range(PARTS + 1, 16'hFFFF));
        end
      endcase
      put_header(id, seq, cnt, part, aseq, apart);
    end
  endtask

  // hold the sender back until every outstanding result has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (checker_pending != 0) @(negedge clk);
  endtask

  initial begin
    bit mid_pause_done;
    mid_pause_done = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    out_stall  = 1'b0;
    command    = CMD_HEADER;
    ident      = '0;
    msg_seq    = '0;
    part_count = '0;
    part_index = '0;
    ack_seq    = '0;
    ack_part   = '0;
    gen_read   = '0;
    for (int i = 0; i < RING; i++) begin
      gen_cnt[i]  = 0;
      gen_sent[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: empty consume, bad format bytes carrying a maximal ack
    put_consume();
    put_header(8'h00, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF);
    put_header(8'hFF, '0, '0, '0, 31'h7FFF_FFFF, 16'hFFFF);
    put_header(8'h79, 31'd1, 16'd1, '0, 31'h7FFF_FFFF, 16'hFFFF);
    // window edges; peer moves on a larger part, stays on a smaller one
    put_header(VALID_IDENT, 31'd0, 16'd1, '0, 31'd0, 16'd5);
    put_header(VALID_IDENT, 31'd8, 16'd1, '0, 31'd0, 16'd3);
    put_header(VALID_IDENT, 31'h7FFF_FFFF, 16'd1, '0, 31'd1, 16'd0);
    // zero and oversized counts leave the slot empty
    put_header(VALID_IDENT, 31'd1, 16'd0, '0, 31'd1, 16'd0);
    put_header(VALID_IDENT, 31'd1, 16'd17, '0, 31'd1, 16'd0);
    // out-of-range part still opens the slot with its count
    put_header(VALID_IDENT, 31'd1, 16'd3, 16'd3, 31'd1, 16'd0);
    // later count ignored once open, then a repeat
    put_header(VALID_IDENT, 31'd1, 16'd9, 16'd1, 31'd1, 16'd0);
    put_header(VALID_IDENT, 31'd1, 16'd3, 16'd1, 31'd1, 16'd0);
    put_header(VALID_IDENT, 31'd1, 16'd3, 16'd0, 31'd1, 16'd0);
    put_header(VALID_IDENT, 31'd2, 16'd16, 16'd15, 31'd1, 16'd0);
    put_consume();
    put_header(VALID_IDENT, 31'd1, 16'd3, 16'd2, 31'd1, 16'd0);
    put_header(VALID_IDENT, 31'd7, 16'd1, 16'd0, 31'd1, 16'd0);
    put_consume();
    put_consume();
    // read point moved: old sequence too late, a smaller seq with big part ignored
    put_header(VALID_IDENT, 31'd1, 16'd1, '0, 31'd0, 16'hFFFF);
    put_header(VALID_IDENT, 31'd8, 16'd1, '0, 31'd1, 16'd0);
    put_header(VALID_IDENT, 31'd9, 16'd1, '0, 31'd1, 16'd0);
    wait_results_drained();

    // random: mostly in-window fragments with consumes, the rest noise
    while (items_sent < ITEMS) begin
      if (items_sent >= ITEMS / 2 && !mid_pause_done) begin
        wait_results_drained();
        mid_pause_done = 1'b1;
      end
      if ($urandom_range(0, 99) < 65) begin
        if (gen_complete(slot_of(gen_read + 1'b1)) && $urandom_range(0, 2) == 0)
          put_consume();
        else
          send_fragment();
      end else begin
        send_noise();
      end
    end

    // let every result out, then idle a while for stray ones
    in_valid <= 1'b0;
    @(negedge clk);
    while (checker_pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("%0d items driven (%0d fragment headers, %0d consume requests), %0d results checked",
             items_sent, header_items, consume_items, report_count);
    $display("status codes returned, one bit per code from 7 down to 0: %b; %0d messages read",
             status_seen, gen_read);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
